### hw/rtl/mouse_cursor_tracker_event_fifo_macros.svh
`ifndef MOUSE_CURSOR_TRACKER_EVENT_FIFO_MACROS_SVH
`define MOUSE_CURSOR_TRACKER_EVENT_FIFO_MACROS_SVH

// concurrent check, masked while reset is high
`define MCTEF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define MCTEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mctef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mctef_pkg;

   localparam int EVENT_DEPTH  = 64;
   localparam int EV_IDX_W     = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam int EV_CNT_W     = $clog2(EVENT_DEPTH + 1);

   localparam int RSPQ_DEPTH   = 3;
   localparam int RSPQ_IDX_W   = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W   = $clog2(RSPQ_DEPTH + 1);

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VISIBLE   = 3'd4;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam logic signed [15:0] CURSOR_RESET = 16'sd100;

   typedef struct packed {
      logic              op;
      logic [7:0]        status_byte;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cursor_x_out;
      logic signed [15:0] cursor_y_out;
      logic               left_down;
      logic               right_down;
      logic               left_press;
      logic               left_release;
      logic               event_valid;
      logic signed [7:0]  event_dx;
      logic signed [7:0]  event_dy;
      logic               event_left;
      logic               event_right;
      logic               event_dropped;
   } rsp_type;

   typedef struct packed {
      logic [14:0] screen_width_limit;
      logic [14:0] screen_height_limit;
      logic [7:0]  pointer_width;
      logic [7:0]  pointer_height;
      logic [7:0]  min_visible;
   } cfg_type;

   typedef struct packed {
      logic       right;
      logic       left;
      logic [7:0] dy;
      logic [7:0] dx;
   } event_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               left;
      logic               right;
   } cursor_type;

   typedef struct packed {
      logic clicked;
      logic released;
   } edge_type;

   typedef struct packed {
      logic hit;
      logic dropped;
   } evq_status_type;

endpackage

`default_nettype wire

### hw/rtl/mctef_cursor.sv
`timescale 1ns / 1ps
`default_nettype none

module mctef_cursor (
   input  wire                     clock,
   input  wire                     reset,
   input  mctef_pkg::cfg_type      cfg,
   input  wire                     upd_en,
   input  wire  [7:0]              status_byte,
   input  wire  signed [7:0]       delta_x,
   input  wire  signed [7:0]       delta_y,
   output mctef_pkg::cursor_type   cur,
   output mctef_pkg::edge_type     edges
);
   import mctef_pkg::*;

   logic signed [15:0] cur_x_ff, cur_x_in;
   logic signed [15:0] cur_y_ff, cur_y_in;
   logic               left_ff, left_in;
   logic               right_ff, right_in;

   logic signed [17:0] sum_x, sum_y;
   logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [17:0] clo_x, clo_y, fin_x, fin_y;

   always_comb begin
      sum_x = {{2{cur_x_ff[15]}}, cur_x_ff} + {{10{delta_x[7]}}, delta_x};
      sum_y = {{2{cur_y_ff[15]}}, cur_y_ff} - {{10{delta_y[7]}}, delta_y};
      lo_x  = {10'b0, cfg.min_visible} - {10'b0, cfg.pointer_width};
      lo_y  = {10'b0, cfg.min_visible} - {10'b0, cfg.pointer_height};
      hi_x  = {3'b0, cfg.screen_width_limit} - {10'b0, cfg.min_visible};
      hi_y  = {3'b0, cfg.screen_height_limit} - {10'b0, cfg.min_visible};
      clo_x = (sum_x < lo_x) ? lo_x : sum_x;
      clo_y = (sum_y < lo_y) ? lo_y : sum_y;
      fin_x = (clo_x >= hi_x) ? hi_x : clo_x;
      fin_y = (clo_y >= hi_y) ? hi_y : clo_y;

      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (upd_en) begin
         cur_x_in = fin_x[15:0];
         cur_y_in = fin_y[15:0];
         left_in  = status_byte[0];
         right_in = status_byte[1];
      end

      edges.clicked  = status_byte[0] & ~left_ff;
      edges.released = ~status_byte[0] & left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= CURSOR_RESET;
         cur_y_ff <= CURSOR_RESET;
         left_ff  <= 1'b0;
         right_ff <= 1'b0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign cur.x     = cur_x_ff;
   assign cur.y     = cur_y_ff;
   assign cur.left  = left_ff;
   assign cur.right = right_ff;

endmodule

`default_nettype wire

### hw/rtl/mctef_event_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mctef_event_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  mctef_pkg::event_type       push_data,
   input  wire                        pop,
   output mctef_pkg::evq_status_type  status,
   output mctef_pkg::event_type       rd_data
);
   import mctef_pkg::*;

   event_type             mem [EVENT_DEPTH];
   event_type             rd_data_ff;

   logic [EV_IDX_W-1:0]   head_ff, head_in;
   logic [EV_IDX_W-1:0]   tail_ff, tail_in;
   logic [EV_CNT_W-1:0]   count_ff, count_in;
   logic                  full, nonempty, pop_do;

   function automatic logic [EV_IDX_W-1:0] next_idx(input logic [EV_IDX_W-1:0] i);
      logic [EV_IDX_W-1:0] n;
      n = (i == EV_IDX_W'(EVENT_DEPTH - 1)) ? '0 : i + 1'b1;
      return n;
   endfunction

   always_comb begin
      full     = (count_ff == EV_CNT_W'(EVENT_DEPTH));
      nonempty = (count_ff != '0);
      pop_do   = pop & nonempty;

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = next_idx(tail_ff);
         if (full) begin
            head_in = next_idx(head_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (pop_do) begin
         head_in  = next_idx(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_data;
      end
      if (pop_do) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign status.hit     = nonempty;
   assign status.dropped = full;
   assign rd_data        = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/mctef_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mctef_rsp_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  mctef_pkg::rsp_type           push_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output mctef_pkg::rsp_type           rsp_data,
   output logic [mctef_pkg::RSPQ_CNT_W-1:0] level
);
   import mctef_pkg::*;

   rsp_type                entry_ff [RSPQ_DEPTH];
   logic [RSPQ_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   pop;

   function automatic logic [RSPQ_IDX_W-1:0] next_ptr(input logic [RSPQ_IDX_W-1:0] p);
      logic [RSPQ_IDX_W-1:0] n;
      n = (p == RSPQ_IDX_W'(RSPQ_DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   always_comb begin
      pop       = rsp_valid & rsp_ready;
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign level     = cnt_ff;

endmodule

`default_nettype wire

### hw/rtl/mouse_cursor_tracker_event_fifo.sv
// channel  | signals                              | transfer when
// ---------+--------------------------------------+------------------------
// req      | req_valid, req_ready, req_data       | req_valid && req_ready
// rsp      | rsp_valid, rsp_ready, rsp_data       | rsp_valid && rsp_ready
// csr      | csr_wr_en, csr_index, csr_wdata      | csr_wr_en
//
// one item per cycle sustained while req_ready is high; a result passes the stage
// register and then the output queue, and the event ram read is registered
// cursor add and clamp plus at most one event ram access per item, all in the accept cycle
// synchronous reset sets the cursor to its reset position, clears buttons, queue pointers and the
// stage register, loads config defaults; the event ram is not cleared, unwritten entries are never read
// results wait in a three-entry queue; req_ready depends on registered occupancy only
`timescale 1ns / 1ps
`default_nettype none

module mouse_cursor_tracker_event_fifo (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  mctef_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output mctef_pkg::rsp_type                   rsp_data,
   input  wire                                  csr_wr_en,
   input  wire  [mctef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [mctef_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mctef_pkg::*;

   typedef struct packed {
      logic valid;
      logic ev_hit;
      logic clicked;
      logic released;
      logic dropped;
   } stage_type;

   cfg_type                cfg_ff, cfg_in;
   stage_type              s1_ff, s1_in;

   logic                   accept, is_packet, is_pop;
   cursor_type             cur;
   edge_type               edges;
   evq_status_type         evq_status;
   event_type              push_ev, rd_ev;
   rsp_type                result;
   logic [RSPQ_CNT_W-1:0]  rspq_level;
   logic [RSPQ_CNT_W:0]    pending;

   always_comb begin
      pending   = {1'b0, rspq_level} + {{RSPQ_CNT_W{1'b0}}, s1_ff.valid};
      req_ready = (pending < (RSPQ_CNT_W + 1)'(RSPQ_DEPTH));
      accept    = req_valid & req_ready;
      is_packet = accept & (req_data.op == OP_PACKET);
      is_pop    = accept & (req_data.op == OP_POP);

      push_ev.dx    = req_data.delta_x;
      push_ev.dy    = req_data.delta_y;
      push_ev.left  = req_data.status_byte[0];
      push_ev.right = req_data.status_byte[1];
   end

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_in.screen_width_limit  = csr_wdata;
            CSR_SCREEN_HEIGHT: cfg_in.screen_height_limit = csr_wdata;
            CSR_CURSOR_WIDTH:  cfg_in.pointer_width       = csr_wdata[7:0];
            CSR_CURSOR_HEIGHT: cfg_in.pointer_height      = csr_wdata[7:0];
            CSR_MIN_VISIBLE:   cfg_in.min_visible         = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_in.valid    = accept;
      s1_in.ev_hit   = is_pop & evq_status.hit;
      s1_in.clicked  = is_packet & edges.clicked;
      s1_in.released = is_packet & edges.released;
      s1_in.dropped  = is_packet & evq_status.dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width_limit  <= '0;
         cfg_ff.screen_height_limit <= '0;
         cfg_ff.pointer_width       <= 8'd16;
         cfg_ff.pointer_height      <= 8'd16;
         cfg_ff.min_visible         <= 8'd4;
         s1_ff                      <= '0;
      end else begin
         cfg_ff <= cfg_in;
         s1_ff  <= s1_in;
      end
   end

   mctef_cursor u_cursor (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .upd_en      (is_packet),
      .status_byte (req_data.status_byte),
      .delta_x     (req_data.delta_x),
      .delta_y     (req_data.delta_y),
      .cur         (cur),
      .edges       (edges)
   );

   mctef_event_queue u_event_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (is_packet),
      .push_data (push_ev),
      .pop       (is_pop),
      .status    (evq_status),
      .rd_data   (rd_ev)
   );

   // result assembly, cursor registers already hold the post-item state
   always_comb begin
      result.cursor_x_out  = cur.x;
      result.cursor_y_out  = cur.y;
      result.left_down     = cur.left;
      result.right_down    = cur.right;
      result.left_press    = s1_ff.clicked;
      result.left_release  = s1_ff.released;
      result.event_valid   = s1_ff.ev_hit;
      result.event_dx      = s1_ff.ev_hit ? rd_ev.dx : 8'sd0;
      result.event_dy      = s1_ff.ev_hit ? rd_ev.dy : 8'sd0;
      result.event_left    = s1_ff.ev_hit & rd_ev.left;
      result.event_right   = s1_ff.ev_hit & rd_ev.right;
      result.event_dropped = s1_ff.dropped;
   end

   mctef_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_ff.valid),
      .push_data (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .level     (rspq_level)
   );

endmodule

`default_nettype wire

### hw/rtl/mctef_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "mouse_cursor_tracker_event_fifo_macros.svh"

module mctef_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input mctef_pkg::rsp_type  rsp_data
);

   `MCTEF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped before transfer")
   `MCTEF_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp payload changed while stalled")
   `MCTEF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid right after reset")
   `MCTEF_ASSERT(a_rsp_origin, clock, reset, rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready, 2), "rsp without a request two cycles earlier")

endmodule

bind mouse_cursor_tracker_event_fifo mctef_checker u_mctef_checker (.*);

`default_nettype wire

### test/mouse_cursor_tracker_event_fifo_checker.sv
`timescale 1ns / 1ps

module mouse_cursor_tracker_event_fifo_checker (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire                                  req_ready,
   input  mctef_pkg::req_type                   req_data,
   input  wire                                  rsp_valid,
   input  wire                                  rsp_ready,
   input  mctef_pkg::rsp_type                   rsp_data,
   input  wire                                  csr_wr_en,
   input  wire  [mctef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [mctef_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                   fail_count,
   output int                                   pending_count
);

   import mctef_pkg::*;

   cfg_type   cfg;
   int        pos_x;
   int        pos_y;
   logic      left_held;
   logic      right_held;
   event_type event_copy[$];
   rsp_type   awaited_rsp[$];

   rsp_type   want;
   string     diff;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic int clamp_axis(int v, int csize, int smax);
      int lo;
      int hi;
      lo = -(csize - int'(cfg.min_visible));
      hi = smax - int'(cfg.min_visible);
      if (v < lo) v = lo;
      if (v >= hi) v = hi;
      return v;
   endfunction

   function automatic rsp_type cursor_step(req_type it);
      rsp_type   r;
      event_type e;
      logic      lb;
      logic      rb;
      r = '0;
      if (it.op == OP_PACKET) begin
         lb = it.status_byte[0];
         rb = it.status_byte[1];
         // full queue: oldest event is discarded
         if (event_copy.size() >= EVENT_DEPTH) begin
            void'(event_copy.pop_front());
            r.event_dropped = 1'b1;
         end
         e.dx    = it.delta_x;
         e.dy    = it.delta_y;
         e.left  = lb;
         e.right = rb;
         event_copy.push_back(e);
         pos_x = clamp_axis(pos_x + int'($signed(it.delta_x)),
                            int'(cfg.pointer_width), int'(cfg.screen_width_limit));
         pos_y = clamp_axis(pos_y - int'($signed(it.delta_y)),
                            int'(cfg.pointer_height), int'(cfg.screen_height_limit));
         r.left_press   = lb & ~left_held;
         r.left_release = ~lb & left_held;
         left_held  = lb;
         right_held = rb;
      end else if (event_copy.size() != 0) begin
         e = event_copy.pop_front();
         r.event_valid = 1'b1;
         r.event_dx    = e.dx;
         r.event_dy    = e.dy;
         r.event_left  = e.left;
         r.event_right = e.right;
      end
      r.cursor_x_out = pos_x[15:0];
      r.cursor_y_out = pos_y[15:0];
      r.left_down    = left_held;
      r.right_down   = right_held;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.screen_width_limit  = 15'd0;
         cfg.screen_height_limit = 15'd0;
         cfg.pointer_width       = 8'd16;
         cfg.pointer_height      = 8'd16;
         cfg.min_visible         = 8'd4;
         pos_x      = int'(CURSOR_RESET);
         pos_y      = int'(CURSOR_RESET);
         left_held  = 1'b0;
         right_held = 1'b0;
         event_copy.delete();
         awaited_rsp.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  cfg.screen_width_limit  = csr_wdata;
               CSR_SCREEN_HEIGHT: cfg.screen_height_limit = csr_wdata;
               CSR_CURSOR_WIDTH:  cfg.pointer_width       = csr_wdata[7:0];
               CSR_CURSOR_HEIGHT: cfg.pointer_height      = csr_wdata[7:0];
               CSR_MIN_VISIBLE:   cfg.min_visible         = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            awaited_rsp.push_back(cursor_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("rsp transfer with nothing expected: got=%h", rsp_data);
            end else begin
               want = awaited_rsp.pop_front();
               diff = "";
               if (rsp_data.cursor_x_out  !== want.cursor_x_out)  diff = {diff, " cursor_x_out"};
               if (rsp_data.cursor_y_out  !== want.cursor_y_out)  diff = {diff, " cursor_y_out"};
               if (rsp_data.left_down     !== want.left_down)     diff = {diff, " left_down"};
               if (rsp_data.right_down    !== want.right_down)    diff = {diff, " right_down"};
               if (rsp_data.left_press    !== want.left_press)    diff = {diff, " left_press"};
               if (rsp_data.left_release  !== want.left_release)  diff = {diff, " left_release"};
               if (rsp_data.event_valid   !== want.event_valid)   diff = {diff, " event_valid"};
               if (rsp_data.event_dx      !== want.event_dx)      diff = {diff, " event_dx"};
               if (rsp_data.event_dy      !== want.event_dy)      diff = {diff, " event_dy"};
               if (rsp_data.event_left    !== want.event_left)    diff = {diff, " event_left"};
               if (rsp_data.event_right   !== want.event_right)   diff = {diff, " event_right"};
               if (rsp_data.event_dropped !== want.event_dropped) diff = {diff, " event_dropped"};
               if (diff != "") begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("rsp mismatch in%s: exp=%h got=%h (exp x=%0d y=%0d, got x=%0d y=%0d)",
                              diff, want, rsp_data, want.cursor_x_out, want.cursor_y_out,
                              rsp_data.cursor_x_out, rsp_data.cursor_y_out);
               end
            end
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

### test/mouse_cursor_tracker_event_fifo_tb.sv
`timescale 1ns / 1ps

module mouse_cursor_tracker_event_fifo_tb;

   import mctef_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     fail_count;
   int                     pending_count;
   int unsigned            cycle_count = 0;
   logic                   calm = 1'b0;

   mouse_cursor_tracker_event_fifo uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mouse_cursor_tracker_event_fifo_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("mouse_cursor_tracker_event_fifo_tb: FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
   end

   function automatic req_type make_packet(logic [7:0] st, logic [7:0] dx, logic [7:0] dy);
      req_type it;
      it.op          = OP_PACKET;
      it.status_byte = st;
      it.delta_x     = dx;
      it.delta_y     = dy;
      return it;
   endfunction

   function automatic req_type make_pop();
      req_type it;
      it.op          = OP_POP;
      it.status_byte = 8'($urandom_range(255));
      it.delta_x     = 8'($urandom_range(255));
      it.delta_y     = 8'($urandom_range(255));
      return it;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(req_type it);
      if (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < 28) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic set_config(logic [14:0] sw, logic [14:0] sh, logic [7:0] cw,
                             logic [7:0] ch, logic [7:0] mv);
      drain();
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= sw;
      @(negedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= sh;
      @(negedge clock);
      csr_index <= CSR_CURSOR_WIDTH;
      csr_wdata <= {7'($urandom_range(127)), cw};
      @(negedge clock);
      csr_index <= CSR_CURSOR_HEIGHT;
      csr_wdata <= {7'($urandom_range(127)), ch};
      @(negedge clock);
      csr_index <= CSR_MIN_VISIBLE;
      csr_wdata <= {7'($urandom_range(127)), mv};
      @(negedge clock);
      // unmapped index must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= 15'($urandom_range(32767));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // bursts of mostly packets fill the queue past full, bursts of pops drain it
   task automatic run_random(int count, int drift);
      req_type it;
      int      pop_pct;
      int      m;
      pop_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0:       pop_pct = 8;
               1:       pop_pct = 50;
               default: pop_pct = 92;
            endcase
         end
         if (i == count / 2) drain();
         if ($urandom_range(99) < pop_pct) begin
            it = make_pop();
         end else begin
            it = make_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
            if (drift != 0 && $urandom_range(99) < 50) begin
               m = int'($urandom_range(127, 90));
               it.delta_x = 8'(drift * m);
               it.delta_y = 8'(-drift * m);
            end
         end
         send_item(it);
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: empty pop, packet into the tight clamp window, pop it back
      send_item(make_pop());
      send_item(make_packet(8'h00, 8'h00, 8'h00));
      send_item(make_pop());

      set_config(15'd640, 15'd480, 8'd16, 8'd16, 8'd4);
      send_item(make_packet(8'h01, 8'h7f, 8'h7f));
      send_item(make_packet(8'h01, 8'h80, 8'h80));
      send_item(make_packet(8'h02, 8'h80, 8'h7f));
      send_item(make_packet(8'hfc, 8'h00, 8'h00));
      send_item(make_packet(8'hff, 8'h7f, 8'h80));
      // run into the lower clamp
      for (int i = 0; i < 4; i++) send_item(make_packet(8'h00, 8'h80, 8'h7f));
      // run into the upper clamp
      for (int i = 0; i < 6; i++) send_item(make_packet(8'h03, 8'h7f, 8'h80));
      for (int i = 0; i < 4; i++) send_item(make_pop());

      run_random(200, 0);

      set_config(15'd32767, 15'd32767, 8'd255, 8'd255, 8'd0);
      calm <= 1'b1;
      run_random(200, 1);
      calm <= 1'b0;

      // crossed limits, upper clamp wins
      set_config(15'd0, 15'd0, 8'd0, 8'd0, 8'd255);
      run_random(100, -1);

      set_config(15'd200, 15'd150, 8'd255, 8'd8, 8'd255);
      run_random(150, 0);

      set_config(15'd1000, 15'd700, 8'd32, 8'd32, 8'd8);
      run_random(250, -1);

      set_config(15'($urandom_range(32767)), 15'($urandom_range(2000)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random(150, 1);

      drain();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("mouse_cursor_tracker_event_fifo_tb: PASS");
      end else begin
         $display("mouse_cursor_tracker_event_fifo_tb: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mctef_pkg.sv
hw/rtl/mctef_cursor.sv
hw/rtl/mctef_event_queue.sv
hw/rtl/mctef_rsp_queue.sv
hw/rtl/mouse_cursor_tracker_event_fifo.sv
hw/rtl/mctef_checker.sv
test/mouse_cursor_tracker_event_fifo_checker.sv
test/mouse_cursor_tracker_event_fifo_tb.sv
